// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL of the two-fiducial transform.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define TFRT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tfrt assertion failed");

// Checked on every rising edge, reset included.
`define TFRT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tfrt assertion failed");

`endif

// ----- rtl/core/tfrt_pkg.sv -----
// ----------------------------------------------------------------------------
// tfrt_pkg
// Shared constants, types and the CORDIC arctangent table of the
// two-fiducial rigid transform.
// ----------------------------------------------------------------------------
package tfrt_pkg;

   localparam int CORDIC_STEPS_DEF  = 24;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int COORD_W = 32;
   localparam int ANGLE_W = 25;
   localparam int NUM_REGS = 8;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WAFER_FIRST_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAFER_FIRST_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAFER_SECOND_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WAFER_SECOND_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MACHINE_FIRST_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MACHINE_FIRST_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MACHINE_SECOND_X = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MACHINE_SECOND_Y = 3'd7;

   // angles in Q30 radians
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [36:0] TWO_PI_Q30  = 37'sd6746518852;
   localparam logic signed [59:0] GAIN_INV_Q30 = 60'sd652032874;
   localparam logic signed [32:0] RAD2DEG_Q24 = 33'sd961263668;

   // rotation setup handed to the point pipeline
   typedef struct packed {
      logic                valid;
      logic signed [32:0]  c;
      logic signed [32:0]  s;
      logic signed [35:0]  tx;
      logic signed [35:0]  ty;
      logic signed [ANGLE_W-1:0] angle_deg;
      logic                bad;
   } xform_type;

   function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
      logic signed [35:0] v;
      case (idx)
         5'd0:  v = 36'sd843314857;
         5'd1:  v = 36'sd497837829;
         5'd2:  v = 36'sd263043837;
         5'd3:  v = 36'sd133525159;
         5'd4:  v = 36'sd67021687;
         5'd5:  v = 36'sd33543516;
         5'd6:  v = 36'sd16775851;
         5'd7:  v = 36'sd8388437;
         5'd8:  v = 36'sd4194283;
         5'd9:  v = 36'sd2097149;
         5'd31: v = 36'sd0;
         default: v = 36'sd1 <<< (30 - idx);
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/tfrt_req_if.sv -----
// ----------------------------------------------------------------------------
// tfrt_req_if / tfrt_rsp_if
// Valid/ready channels carrying point words in and transformed words out.
// ----------------------------------------------------------------------------
interface tfrt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic               rotate_only;

   modport source (output valid, point_x, point_y, rotate_only, input ready);
   modport sink   (input valid, point_x, point_y, rotate_only, output ready);
endinterface

interface tfrt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [24:0] angle_deg;
   logic               status;

   modport source (output valid, out_x, out_y, angle_deg, status, input ready);
   modport sink   (input valid, out_x, out_y, angle_deg, status, output ready);
endinterface

// ----- rtl/core/two_fiducial_rigid_transform.sv -----
// ----------------------------------------------------------------------------
// two_fiducial_rigid_transform
// Maps wafer-frame points to machine frame from two fiducial pairs.
// ----------------------------------------------------------------------------
// Every register write restarts a setup pass of CORDIC vectoring for both
// vectors, CORDIC rotation, and then loading, products and checks;
// req.ready stays low until it finishes, also after reset. Then one point word
// is taken every cycle while the output is not stalled, and its result word is
// offered on rsp after four pipeline registers (capture included); a stalled
// output holds the pipeline without losing words.
module two_fiducial_rigid_transform
   import tfrt_pkg::*;
#(
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   tfrt_req_if.sink             req,
   tfrt_rsp_if.source           rsp
);

   xform_type xform;

   tfrt_setup #(
      .CORDIC_STEPS  (CORDIC_STEPS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .xform     (xform)
   );

   tfrt_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .xform (xform),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

// ----- rtl/core/tfrt_setup.sv -----
// ----------------------------------------------------------------------------
// tfrt_setup
// Holds the fiducial registers and, after every write, runs a sequencer
// that finds angle, sine/cosine, translation and the consistency check.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfrt_setup
   import tfrt_pkg::*;
#(
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output xform_type            xform
);

   localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam int IW    = $clog2(STEPS);
   localparam logic [IW-1:0] LAST = IW'(STEPS - 1);
   localparam int THR   = ((1 << FRACTION_BITS) + 5) / 10;
   localparam logic signed [35:0] THR_P = 36'(THR);
   localparam logic signed [35:0] THR_N = -36'(THR);
   localparam logic [46:0] THR_SQ = 47'(THR) * 47'(THR);
   localparam int DSH = 54 - FRACTION_BITS;
   localparam logic signed [65:0] DEG_HALF = 66'sd1 <<< (DSH - 1);
   localparam logic signed [65:0] DEG_LIM  = 66'sd180 <<< FRACTION_BITS;
   localparam logic signed [65:0] RND30    = 66'sd536870912;

   localparam logic [3:0] ST_START    = 4'd0;
   localparam logic [3:0] ST_VEC      = 4'd1;
   localparam logic [3:0] ST_ROT_INIT = 4'd2;
   localparam logic [3:0] ST_ROT      = 4'd3;
   localparam logic [3:0] ST_MUL      = 4'd4;
   localparam logic [3:0] ST_TRANS    = 4'd5;
   localparam logic [3:0] ST_DIFF     = 4'd6;
   localparam logic [3:0] ST_SQ       = 4'd7;
   localparam logic [3:0] ST_CMP      = 4'd8;
   localparam logic [3:0] ST_DONE     = 4'd9;

   logic [31:0]        cfg_ff [NUM_REGS];
   logic [3:0]         state_ff, state_in;
   logic [IW-1:0]      step_ff, step_in;
   logic [3:0]         mstep_ff, mstep_in;
   logic               phase_ff, phase_in;   // 0: machine vector, 1: wafer vector
   logic               zero_ff, zero_in;
   logic               neg_ff, neg_in;
   logic signed [59:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [35:0] z_ff, z_in, zb_ff, zb_in, th_ff, th_in;
   logic signed [32:0] c_ff, c_in, s_ff, s_in;
   logic signed [65:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [35:0] rx1_ff, rx1_in, ry1_ff, ry1_in, rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic signed [35:0] tx_ff, tx_in, ty_ff, ty_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [45:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic               inr_ff, inr_in;
   logic               bad_ff, bad_in;
   logic signed [ANGLE_W-1:0] deg_ff, deg_in;

   logic signed [31:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
   logic signed [32:0] ldx, ldy;
   logic signed [59:0] lx, ly, shx, shy;
   logic signed [35:0] lz, atn;
   logic signed [36:0] thw;
   logic signed [32:0] opa, opb;
   logic signed [66:0] rsum;
   logic signed [65:0] dr;
   logic signed [22:0] dxn, dyn;
   logic [3:0]         mj;

   assign a1x = cfg_ff[REG_WAFER_FIRST_X];
   assign a1y = cfg_ff[REG_WAFER_FIRST_Y];
   assign a2x = cfg_ff[REG_WAFER_SECOND_X];
   assign a2y = cfg_ff[REG_WAFER_SECOND_Y];
   assign b1x = cfg_ff[REG_MACHINE_FIRST_X];
   assign b1y = cfg_ff[REG_MACHINE_FIRST_Y];
   assign b2x = cfg_ff[REG_MACHINE_SECOND_X];
   assign b2y = cfg_ff[REG_MACHINE_SECOND_Y];

   // vector loader: machine vector first, then wafer vector
   always_comb begin
      if (state_ff == ST_START) begin
         ldx = 33'(b2x) - 33'(b1x);
         ldy = 33'(b2y) - 33'(b1y);
      end else begin
         ldx = 33'(a2x) - 33'(a1x);
         ldy = 33'(a2y) - 33'(a1y);
      end
      lx = 60'(ldx) <<< 24;
      ly = 60'(ldy) <<< 24;
      lz = '0;
      if (lx < 0) begin
         lz = (ly >= 0) ? PI_Q30 : -PI_Q30;
         lx = -lx;
         ly = -ly;
      end
   end

   assign shx = vx_ff >>> step_ff;
   assign shy = vy_ff >>> step_ff;
   assign atn = atan_q30(5'(step_ff));
   assign mj  = mstep_ff - 4'd1;

   // shared multiplier operands
   always_comb begin
      case (mstep_ff)
         4'd0, 4'd3, 4'd4, 4'd7: opa = c_ff;
         4'd1, 4'd2, 4'd5, 4'd6: opa = s_ff;
         default:                opa = 33'(th_ff);
      endcase
      case (mstep_ff)
         4'd0, 4'd2: opb = 33'(a1x);
         4'd1, 4'd3: opb = 33'(a1y);
         4'd4, 4'd6: opb = 33'(a2x);
         4'd5, 4'd7: opb = 33'(a2y);
         default:    opb = RAD2DEG_Q24;
      endcase
   end

   assign rsum = (mj == 4'd1 || mj == 4'd5) ? (67'(acc_ff) - 67'(prod_ff) + 67'(RND30))
                                            : (67'(acc_ff) + 67'(prod_ff) + 67'(RND30));
   assign dr   = (prod_ff + DEG_HALF) >>> DSH;
   assign dxn  = dx_ff[22:0];
   assign dyn  = dy_ff[22:0];

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      mstep_in = mstep_ff;
      phase_in = phase_ff;
      zero_in  = zero_ff;
      neg_in   = neg_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      z_in     = z_ff;
      zb_in    = zb_ff;
      th_in    = th_ff;
      c_in     = c_ff;
      s_in     = s_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      rx1_in   = rx1_ff;
      ry1_in   = ry1_ff;
      rx2_in   = rx2_ff;
      ry2_in   = ry2_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sqx_in   = sqx_ff;
      sqy_in   = sqy_ff;
      inr_in   = inr_ff;
      bad_in   = bad_ff;
      deg_in   = deg_ff;
      thw      = '0;
      case (state_ff)
         ST_START: begin
            vx_in    = lx;
            vy_in    = ly;
            z_in     = lz;
            zero_in  = (ldx == 0) && (ldy == 0);
            phase_in = 1'b0;
            step_in  = '0;
            state_in = ST_VEC;
         end
         ST_VEC: begin
            if (vy_ff > 0) begin
               vx_in = vx_ff + shy;
               vy_in = vy_ff - shx;
               z_in  = z_ff + atn;
            end else begin
               vx_in = vx_ff - shy;
               vy_in = vy_ff + shx;
               z_in  = z_ff - atn;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST) begin
               step_in = '0;
               if (!phase_ff) begin
                  // keep the machine angle, a zero vector counts as angle 0
                  zb_in    = zero_ff ? 36'sd0 : z_in;
                  vx_in    = lx;
                  vy_in    = ly;
                  z_in     = lz;
                  zero_in  = (ldx == 0) && (ldy == 0);
                  phase_in = 1'b1;
               end else begin
                  // final step result is unused when the vector was zero
                  thw = 37'(zb_ff) - 37'(zero_ff ? 36'sd0 : z_in);
                  if (thw > 37'(PI_Q30)) thw = thw - TWO_PI_Q30;
                  if (thw < -37'(PI_Q30)) thw = thw + TWO_PI_Q30;
                  th_in    = 36'(thw);
                  state_in = ST_ROT_INIT;
               end
            end
         end
         ST_ROT_INIT: begin
            vx_in  = GAIN_INV_Q30;
            vy_in  = '0;
            neg_in = 1'b0;
            z_in   = th_ff;
            if (th_ff > HALF_PI_Q30) begin
               z_in   = th_ff - PI_Q30;
               neg_in = 1'b1;
            end else if (th_ff < -HALF_PI_Q30) begin
               z_in   = th_ff + PI_Q30;
               neg_in = 1'b1;
            end
            step_in  = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (z_ff >= 0) begin
               vx_in = vx_ff - shy;
               vy_in = vy_ff + shx;
               z_in  = z_ff - atn;
            end else begin
               vx_in = vx_ff + shy;
               vy_in = vy_ff - shx;
               z_in  = z_ff + atn;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST) begin
               c_in     = neg_ff ? -33'(vx_in) : 33'(vx_in);
               s_in     = neg_ff ? -33'(vy_in) : 33'(vy_in);
               mstep_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // one product per cycle, consumed in the cycle after
            if (mstep_ff <= 4'd8) prod_in = 66'(opa) * 66'(opb);
            if (mstep_ff != 4'd0) begin
               case (mj)
                  4'd0, 4'd2, 4'd4, 4'd6: acc_in = prod_ff;
                  4'd1: rx1_in = 36'(rsum >>> 30);
                  4'd3: ry1_in = 36'(rsum >>> 30);
                  4'd5: rx2_in = 36'(rsum >>> 30);
                  4'd7: ry2_in = 36'(rsum >>> 30);
                  default: begin
                     if (dr > DEG_LIM || dr < -DEG_LIM || dr > 66'sd16777215
                         || dr < -66'sd16777216) begin
                        if (dr > 66'sd0) deg_in = (DEG_LIM > 66'sd16777215) ?
                           25'sd16777215 : 25'(DEG_LIM);
                        else deg_in = (DEG_LIM > 66'sd16777216) ?
                           -25'sd16777216 : -25'(DEG_LIM);
                     end else begin
                        deg_in = 25'(dr);
                     end
                  end
               endcase
            end
            mstep_in = mstep_ff + 4'd1;
            if (mstep_ff == 4'd9) state_in = ST_TRANS;
         end
         ST_TRANS: begin
            tx_in    = 36'(b1x) - rx1_ff;
            ty_in    = 36'(b1y) - ry1_ff;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // the first fiducial maps onto itself exactly; only the second is checked
            dx_in    = rx2_ff + tx_ff - 36'(b2x);
            dy_in    = ry2_ff + ty_ff - 36'(b2y);
            state_in = ST_SQ;
         end
         ST_SQ: begin
            inr_in   = (dx_ff <= THR_P) && (dx_ff >= THR_N)
                    && (dy_ff <= THR_P) && (dy_ff >= THR_N);
            sqx_in   = 46'(dxn) * 46'(dxn);
            sqy_in   = 46'(dyn) * 46'(dyn);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            bad_in   = !inr_ff || ((47'(sqx_ff) + 47'(sqy_ff)) > THR_SQ);
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_DONE;
         default: state_in = ST_START;
      endcase
      if (csr_we) state_in = ST_START;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) cfg_ff[i] <= '0;
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      mstep_ff <= mstep_in;
      phase_ff <= phase_in;
      zero_ff  <= zero_in;
      neg_ff   <= neg_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      z_ff     <= z_in;
      zb_ff    <= zb_in;
      th_ff    <= th_in;
      c_ff     <= c_in;
      s_ff     <= s_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      rx1_ff   <= rx1_in;
      ry1_ff   <= ry1_in;
      rx2_ff   <= rx2_in;
      ry2_ff   <= ry2_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      inr_ff   <= inr_in;
      bad_ff   <= bad_in;
      deg_ff   <= deg_in;
   end

   assign xform.valid     = (state_ff == ST_DONE);
   assign xform.c         = c_ff;
   assign xform.s         = s_ff;
   assign xform.tx        = tx_ff;
   assign xform.ty        = ty_ff;
   assign xform.angle_deg = deg_ff;
   assign xform.bad       = bad_ff;

   `TFRT_ASSERT(a_write_restarts, clock, reset, csr_we |=> !xform.valid)
   `TFRT_ASSERT(a_done_holds, clock, reset,
      (xform.valid && !csr_we) |=> (xform.valid && $stable(xform.c) && $stable(xform.tx)))
   `TFRT_ASSERT_ALWAYS(a_reset_busy, clock, reset |=> !xform.valid)

endmodule

// ----- rtl/core/tfrt_datapath.sv -----
// ----------------------------------------------------------------------------
// tfrt_datapath
// Four-stage point pipeline: capture, rotate products, round, translate
// and saturate. Each stage advances when its successor has room.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfrt_datapath
   import tfrt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  xform_type  xform,
   tfrt_req_if.sink   req,
   tfrt_rsp_if.source rsp
);

   localparam logic signed [66:0] RND30   = 67'sd536870912;
   localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
   localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

   logic               v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic               en1, en2, en3, en4;
   logic signed [31:0] px1_ff, py1_ff;
   logic               ro1_ff, ro2_ff, ro3_ff;
   logic signed [65:0] pxc_ff, pys_ff, pxs_ff, pyc_ff;
   logic signed [35:0] ox3_ff, oy3_ff;
   logic signed [31:0] ox4_ff, ox4_in, oy4_ff, oy4_in;
   logic signed [66:0] sx, sy;
   logic signed [36:0] tx_sum, ty_sum;

   // stage enables
   assign en4 = !v4_ff || rsp.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req.ready = en1 && xform.valid;

   assign v1_in = en1 ? (req.valid && req.ready) : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1: capture the word
   always_ff @(posedge clock) begin
      if (en1) begin
         px1_ff <= req.point_x;
         py1_ff <= req.point_y;
         ro1_ff <= req.rotate_only;
      end
   end

   // stage 2: rotation products
   always_ff @(posedge clock) begin
      if (en2) begin
         pxc_ff <= 66'(xform.c) * 66'(px1_ff);
         pys_ff <= 66'(xform.s) * 66'(py1_ff);
         pxs_ff <= 66'(xform.s) * 66'(px1_ff);
         pyc_ff <= 66'(xform.c) * 66'(py1_ff);
         ro2_ff <= ro1_ff;
      end
   end

   // stage 3: sum and round half up to coordinate precision
   assign sx = 67'(pxc_ff) - 67'(pys_ff) + RND30;
   assign sy = 67'(pxs_ff) + 67'(pyc_ff) + RND30;

   always_ff @(posedge clock) begin
      if (en3) begin
         ox3_ff <= 36'(sx >>> 30);
         oy3_ff <= 36'(sy >>> 30);
         ro3_ff <= ro2_ff;
      end
   end

   // stage 4: translate, saturate, blank on mismatch
   assign tx_sum = 37'(ox3_ff) + (ro3_ff ? 37'sd0 : 37'(xform.tx));
   assign ty_sum = 37'(oy3_ff) + (ro3_ff ? 37'sd0 : 37'(xform.ty));

   always_comb begin
      if (tx_sum > SAT_MAX)      ox4_in = 32'(SAT_MAX);
      else if (tx_sum < SAT_MIN) ox4_in = 32'(SAT_MIN);
      else                       ox4_in = 32'(tx_sum);
      if (ty_sum > SAT_MAX)      oy4_in = 32'(SAT_MAX);
      else if (ty_sum < SAT_MIN) oy4_in = 32'(SAT_MIN);
      else                       oy4_in = 32'(ty_sum);
      if (xform.bad) begin
         ox4_in = '0;
         oy4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         ox4_ff <= ox4_in;
         oy4_ff <= oy4_in;
      end
   end

   assign rsp.valid     = v4_ff;
   assign rsp.out_x     = ox4_ff;
   assign rsp.out_y     = oy4_ff;
   assign rsp.angle_deg = xform.angle_deg;
   assign rsp.status    = xform.bad;

   `TFRT_ASSERT(a_mismatch_zero, clock, reset,
      (rsp.valid && rsp.status) |-> (rsp.out_x == 0 && rsp.out_y == 0))
   `TFRT_ASSERT(a_no_accept_busy, clock, reset, !xform.valid |-> !req.ready)
   `TFRT_ASSERT(a_words_advance, clock, reset,
      (v3_ff && !v4_ff) |=> v4_ff)

endmodule

// ----- tb/tb_two_fiducial_rigid_transform.sv -----
// ----------------------------------------------------------------------------
// tb_two_fiducial_rigid_transform
// Drives point words through the two-fiducial transform under several fiducial
// settings and checks every result word against a typed result or a bit-exact
// CORDIC predictor. A directed table with extreme sets comes first, then random
// rigid and inconsistent fiducial sets with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_two_fiducial_rigid_transform;
   import tfrt_pkg::*;

   localparam int STEPS = 24;
   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_WORDS = 600;
   localparam int WORDS_PER_SET = 100;
   localparam longint ANG_PI = 64'sd3373259426;
   localparam longint ANG_HALF_PI = 64'sd1686629713;
   localparam longint ANG_TWO_PI = 64'sd6746518852;
   localparam longint ROT_START = 64'sd652032874;
   localparam longint TO_DEGREES = 64'sd961263668;
   localparam longint VEC_GAIN = 64'sd16777216;
   localparam logic [31:0] MAX32 = 32'h7fffffff;
   localparam logic [31:0] MIN32 = 32'h80000000;

   localparam longint ARCTAN [32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [24:0] deg;
      logic               bad;
   } placement_type;

   // directed row: fiducial set, point, and a typed result where obvious
   typedef struct packed {
      logic [1:0]    set_sel;
      logic [31:0]   px;
      logic [31:0]   py;
      logic          rot_only;
      logic          typed;
      placement_type want;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_WAFER_FIRST_X;
   logic [31:0] csr_wdata = '0;

   tfrt_req_if req_ch ();
   tfrt_rsp_if rsp_ch ();

   two_fiducial_rigid_transform u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // fiducial copy: wafer A1 A2, machine B1 B2 (x, y each)
   longint fid [8];
   placement_type placements_due [$];
   int errors = 0;
   int words_checked = 0;
   int mismatch_words = 0;
   int idle_send_pct = 0;
   int idle_recv_pct = 0;
   int quiet_cycles = 0;

   // fiducial sets of the directed part
   logic [31:0] fixed_sets [4][8] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0},
      // same direction, second machine fiducial 2.0 too far
      '{0, 0, 32'h00010000, 0, 0, 0, 32'h00030000, 0},
      '{MAX32, MAX32, MAX32, MAX32, MIN32, MIN32, MIN32, MIN32},
      // half-turn across the whole range
      '{MIN32, MIN32, MAX32, MAX32, MAX32, MAX32, MIN32, MIN32}};

   point_row_type point_rows [18] = '{
      '{0, 32'd0, 32'd0, 1'b0, 1'b1, '{32'sd0, 32'sd0, 25'sd0, 1'b0}},
      '{0, 32'd0, 32'd0, 1'b1, 1'b1, '{32'sd0, 32'sd0, 25'sd0, 1'b0}},
      '{0, MAX32, MAX32, 1'b0, 1'b0, '0},
      '{0, MIN32, MIN32, 1'b0, 1'b0, '0},
      '{0, MIN32, MAX32, 1'b1, 1'b0, '0},
      '{0, MAX32, MIN32, 1'b1, 1'b0, '0},
      '{0, 32'd1, 32'hffffffff, 1'b0, 1'b0, '0},
      '{1, 32'd0, 32'd0, 1'b0, 1'b1, '{32'sd0, 32'sd0, 25'sd0, 1'b1}},
      '{1, MAX32, MIN32, 1'b1, 1'b1, '{32'sd0, 32'sd0, 25'sd0, 1'b1}},
      '{1, 32'h00123456, 32'hfedcba98, 1'b0, 1'b1, '{32'sd0, 32'sd0, 25'sd0, 1'b1}},
      '{2, 32'd0, 32'd0, 1'b0, 1'b0, '0},
      '{2, MAX32, MAX32, 1'b0, 1'b0, '0},
      '{2, MIN32, MIN32, 1'b1, 1'b0, '0},
      '{3, 32'd0, 32'd0, 1'b0, 1'b0, '0},
      '{3, MAX32, MIN32, 1'b0, 1'b0, '0},
      '{3, MIN32, MAX32, 1'b1, 1'b0, '0},
      '{3, 32'h00010000, 32'h00020000, 1'b0, 1'b0, '0},
      '{3, MIN32, MIN32, 1'b0, 1'b0, '0}};

   // round half up from q fraction bits
   function automatic longint round_shift(longint v, int q);
      return (v + (64'sd1 <<< (q - 1))) >>> q;
   endfunction

   // CORDIC vectoring: direction of (x, y) in Q30 radians
   function automatic longint heading(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * VEC_GAIN;
      y = y * VEC_GAIN;
      if (x < 0) begin
         z = (y >= 0) ? ANG_PI : -ANG_PI;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += ARCTAN[i];
         end else begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end
      end
      return z;
   endfunction

   // CORDIC rotation: cosine and sine of z, Q30
   function automatic void cos_sin(longint z, output longint c, output longint s);
      longint x, y, dx, dy;
      logic flip;
      x = ROT_START;
      y = 0;
      flip = 1'b0;
      if (z > ANG_HALF_PI) begin
         z -= ANG_PI; flip = 1'b1;
      end else if (z < -ANG_HALF_PI) begin
         z += ANG_PI; flip = 1'b1;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // a*x - b*y back to coordinate precision
   function automatic longint turn(longint a, longint b, longint x, longint y);
      return round_shift(a * x - b * y, 30);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // machine-frame placement of one point under the current fiducials
   function automatic placement_type place_point(longint px, longint py, logic rot_only);
      placement_type r;
      longint th, c, s, tx, ty, thr, dx, dy, ox, oy, dg;
      logic bad;
      th = heading(fid[6] - fid[4], fid[7] - fid[5]) - heading(fid[2] - fid[0], fid[3] - fid[1]);
      if (th > ANG_PI) th -= ANG_TWO_PI;
      if (th < -ANG_PI) th += ANG_TWO_PI;
      cos_sin(th, c, s);
      tx = fid[4] - turn(c, s, fid[0], fid[1]);
      ty = fid[5] - turn(s, -c, fid[0], fid[1]);
      thr = ((64'sd1 <<< FRAC) + 5) / 10;
      bad = 1'b0;
      for (int k = 0; k < 2; k++) begin
         dx = turn(c, s, fid[2*k], fid[2*k+1]) + tx - fid[4+2*k];
         dy = turn(s, -c, fid[2*k], fid[2*k+1]) + ty - fid[5+2*k];
         if (dx > thr || dx < -thr || dy > thr || dy < -thr || dx*dx + dy*dy > thr*thr)
            bad = 1'b1;
      end
      dg = clamp(round_shift(th * TO_DEGREES, 54 - FRAC), -(64'sd180 <<< FRAC),
                 64'sd180 <<< FRAC);
      ox = turn(c, s, px, py);
      oy = turn(s, -c, px, py);
      if (!rot_only) begin
         ox += tx; oy += ty;
      end
      ox = clamp(ox, -64'sd2147483648, 64'sd2147483647);
      oy = clamp(oy, -64'sd2147483648, 64'sd2147483647);
      r.x = bad ? 32'sd0 : ox[31:0];
      r.y = bad ? 32'sd0 : oy[31:0];
      r.deg = dg[24:0];
      r.bad = bad;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      errors++;
   endtask

   // write the eight fiducial registers once the pipeline has drained
   task automatic load_fiducials(input logic [31:0] v [8]);
      logic [CSR_IDX_W-1:0] idx [8];
      idx = '{REG_WAFER_FIRST_X, REG_WAFER_FIRST_Y, REG_WAFER_SECOND_X,
              REG_WAFER_SECOND_Y, REG_MACHINE_FIRST_X, REG_MACHINE_FIRST_Y,
              REG_MACHINE_SECOND_X, REG_MACHINE_SECOND_Y};
      while (placements_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= v[i];
         fid[i] = longint'($signed(v[i]));
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // offer one point word, hold it until taken, record its placement
   task automatic send_point(logic [31:0] px, logic [31:0] py, logic rot_only,
                             logic typed, placement_type want);
      placement_type due;
      if (idle_send_pct != 0) begin
         while ($urandom_range(99) < idle_send_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.point_x <= px;
      req_ch.point_y <= py;
      req_ch.rotate_only <= rot_only;
      do @(posedge clock); while (!req_ch.ready);
      due = typed ? want :
         place_point(longint'($signed(px)), longint'($signed(py)), rot_only);
      placements_due = {placements_due, due};
   endtask

   // result word check, receiver stall and watchdog
   always @(posedge clock) begin
      placement_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= idle_recv_pct);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (placements_due.size() == 0) begin
               $display("result word with nothing outstanding");
               errors++;
            end else begin
               want = placements_due.pop_front();
               words_checked++;
               if (want.bad) mismatch_words++;
               if (rsp_ch.out_x !== want.x) report_mismatch("out_x", rsp_ch.out_x, want.x);
               if (rsp_ch.out_y !== want.y) report_mismatch("out_y", rsp_ch.out_y, want.y);
               if (rsp_ch.angle_deg !== want.deg)
                  report_mismatch("angle_deg", rsp_ch.angle_deg, want.deg);
               if (rsp_ch.status !== want.bad)
                  report_mismatch("status", rsp_ch.status, want.bad);
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [31:0] set_now [8];
      longint ax [2], ay [2], z, c, s, tx, ty;
      logic [31:0] px, py;
      int cur_set;
      req_ch.valid = 1'b0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.rotate_only = 1'b0;
      for (int i = 0; i < 8; i++) fid[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table; the reset set needs no register write
      cur_set = 0;
      foreach (point_rows[r]) begin
         if (point_rows[r].set_sel != cur_set) begin
            req_ch.valid <= 1'b0;
            cur_set = point_rows[r].set_sel;
            set_now = fixed_sets[cur_set];
            load_fiducials(set_now);
         end
         send_point(point_rows[r].px, point_rows[r].py, point_rows[r].rot_only,
                    point_rows[r].typed, point_rows[r].want);
      end

      // random part: new fiducial set every block, idling by thirds
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 200 == 0) begin
            idle_send_pct = (n == 0) ? 24 : (n == 200) ? 49 : 0;
            idle_recv_pct = (n == 0) ? 49 : (n == 200) ? 24 : 0;
         end
         if (n % WORDS_PER_SET == 0) begin
            req_ch.valid <= 1'b0;
            case ((n / WORDS_PER_SET) % 3)
               2: begin
                  // unrelated fiducials, almost always inconsistent
                  for (int i = 0; i < 8; i++)
                     set_now[i] = (i % 3 == 0) ? $urandom : $urandom_range(0, 32'h7ffff) - 32'h40000;
               end
               default: begin
                  // rigid motion of two random fiducials with a little noise
                  for (int k = 0; k < 2; k++) begin
                     ax[k] = longint'($signed($urandom_range(0, 32'h1fffff))) - 64'sh100000;
                     ay[k] = longint'($signed($urandom_range(0, 32'h1fffff))) - 64'sh100000;
                  end
                  z = longint'($signed($urandom)) + (longint'($signed($urandom)) >>> 1);
                  cos_sin(z, c, s);
                  tx = longint'($signed($urandom_range(0, 32'h1ffffff))) - 64'sh1000000;
                  ty = longint'($signed($urandom_range(0, 32'h1ffffff))) - 64'sh1000000;
                  for (int k = 0; k < 2; k++) begin
                     set_now[2*k] = ax[k][31:0];
                     set_now[2*k+1] = ay[k][31:0];
                     set_now[4+2*k] = 32'(turn(c, s, ax[k], ay[k]) + tx
                                         + $urandom_range(0, 64) - 32);
                     set_now[5+2*k] = 32'(turn(s, -c, ax[k], ay[k]) + ty
                                         + $urandom_range(0, 64) - 32);
                  end
               end
            endcase
            load_fiducials(set_now);
         end
         if ($urandom_range(3) == 0) begin
            px = $urandom;
            py = $urandom;
         end else begin
            px = $urandom_range(0, 32'h7fffff) - 32'h400000;
            py = $urandom_range(0, 32'h7fffff) - 32'h400000;
         end
         send_point(px, py, 1'($urandom_range(1)), 1'b0, '0);
      end
      req_ch.valid <= 1'b0;

      while (placements_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("checked %0d result words over %0d fiducial sets, %0d flagged inconsistent",
               words_checked, 4 + RANDOM_WORDS / WORDS_PER_SET, mismatch_words);
      $display("idling covered sender-heavy, receiver-heavy and back-to-back traffic");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
